// ===== sv/xlsu_pkg.sv =====
package xlsu_pkg;

   localparam int DataWidth  = 32;
   localparam int CountWidth = 5;
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   typedef enum logic [3:0] {
      OP_TEST  = 4'd0,
      OP_AND   = 4'd1,
      OP_XOR   = 4'd2,
      OP_OR    = 4'd3,
      OP_SAR   = 4'd4,
      OP_SHL   = 4'd5,
      OP_SHR   = 4'd6,
      OP_SETCC = 4'd7,
      OP_NOT   = 4'd8,
      OP_SHRD  = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      SIZE_BYTE  = 2'd0,
      SIZE_WORD  = 2'd1,
      SIZE_DWORD = 2'd2
   } size_type;

   typedef enum logic [3:0] {
      K_TEST,
      K_AND,
      K_XOR,
      K_OR,
      K_SAR,
      K_SHL,
      K_SHR,
      K_SETCC,
      K_NOT,
      K_SHRD,
      K_NONE
   } kind_type;

   typedef enum logic [1:0] {
      W8,
      W16,
      W32
   } width_type;

   typedef enum logic [2:0] {
      CC_O  = 3'd0,
      CC_B  = 3'd1,
      CC_E  = 3'd2,
      CC_BE = 3'd3,
      CC_S  = 3'd4,
      CC_P  = 3'd5,
      CC_L  = 3'd6,
      CC_LE = 3'd7
   } cond_pair_type;

   typedef struct packed {
      logic [3:0]           operation;
      logic [1:0]           size_code;
      logic [DataWidth-1:0] dest_value;
      logic [DataWidth-1:0] src_value;
      logic [DataWidth-1:0] src2_value;
      logic [3:0]           condition;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic                 write_back;
      logic                 carry_flag;
      logic                 overflow_flag;
      logic                 sign_flag;
      logic                 zero_flag;
      logic                 parity_flag;
   } rsp_type;

   typedef struct packed {
      kind_type              kind;
      width_type             width;
      logic [DataWidth-1:0]  dest;
      logic [DataWidth-1:0]  src;
      logic [CountWidth-1:0] count;
      logic [DataWidth-1:0]  src2;
      logic [3:0]            condition;
   } work_type;

   typedef struct packed {
      logic cf;
      logic of;
      logic sf;
      logic zf;
      logic pf;
   } flags_type;

   function automatic logic [DataWidth-1:0] width_mask(width_type w);
      logic [DataWidth-1:0] m;
      unique case (w)
         W8:      m = {{(DataWidth-8){1'b0}}, 8'hff};
         W16:     m = {{(DataWidth-16){1'b0}}, 16'hffff};
         default: m = {DataWidth{1'b1}};
      endcase
      return m;
   endfunction

   function automatic logic top_bit(logic [DataWidth-1:0] v, width_type w);
      logic b;
      unique case (w)
         W8:      b = v[7];
         W16:     b = v[15];
         default: b = v[DataWidth-1];
      endcase
      return b;
   endfunction

endpackage

// ===== sv/xlsu_front.sv =====
module xlsu_front
   import xlsu_pkg::*;
(
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_item,
   input  logic     queue_full,
   output logic     push,
   output work_type push_item
);

   kind_type             kind;
   width_type            width;
   logic [DataWidth-1:0] mask;

   always_comb begin
      unique case (req_item.operation)
         OP_TEST:  kind = K_TEST;
         OP_AND:   kind = K_AND;
         OP_XOR:   kind = K_XOR;
         OP_OR:    kind = K_OR;
         OP_SAR:   kind = K_SAR;
         OP_SHL:   kind = K_SHL;
         OP_SHR:   kind = K_SHR;
         OP_SETCC: kind = K_SETCC;
         OP_NOT:   kind = K_NOT;
         OP_SHRD:  kind = K_SHRD;
         default:  kind = K_NONE;
      endcase
   end

   always_comb begin
      unique case (req_item.size_code)
         SIZE_BYTE: width = W8;
         SIZE_WORD: width = W16;
         default:   width = W32;
      endcase
   end

   assign mask = width_mask(width);

   // The destination is kept whole because the double shift uses all 32 bits.
   always_comb begin
      push_item.kind      = kind;
      push_item.width     = width;
      push_item.dest      = req_item.dest_value;
      push_item.src       = req_item.src_value & mask;
      push_item.count     = req_item.src_value[CountWidth-1:0];
      push_item.src2      = req_item.src2_value;
      push_item.condition = req_item.condition;
   end

   assign req_stall = queue_full | reset;
   assign push      = req_valid & ~req_stall;

endmodule

// ===== sv/xlsu_queue.sv =====
module xlsu_queue
   import xlsu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop,
   output work_type pop_item
);

   work_type                 entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;

   assign full      = count_ff == QueueCntWidth'(QueueDepth);
   assign pop_valid = count_ff != '0;
   assign pop_item  = entry_ff[rd_ptr_ff];

   function automatic logic [QueuePtrWidth-1:0] next_ptr(logic [QueuePtrWidth-1:0] p);
      logic [QueuePtrWidth-1:0] n;
      if (p == QueuePtrWidth'(QueueDepth - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push & ~pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop & ~push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/xlsu_back.sv =====
module xlsu_back
   import xlsu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     work_valid,
   input  work_type work_item,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_item
);

   flags_type            flags_ff, flags_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [DataWidth-1:0] mask;
   logic [DataWidth-1:0] dest;
   logic [DataWidth-1:0] res;
   logic [DataWidth-1:0] sar_fill;
   logic                 wb;
   logic                 cond;
   logic                 szp_update;
   logic                 co_clear;
   logic [5:0]           back_count;

   assign mask       = width_mask(work_item.width);
   assign dest       = work_item.dest & mask;
   assign back_count = 6'(DataWidth) - {1'b0, work_item.count};
   assign sar_fill   = (top_bit(dest, work_item.width) && work_item.count != '0)
                     ? ~({DataWidth{1'b1}} >> work_item.count) : '0;

   always_comb begin
      unique case (cond_pair_type'(work_item.condition[3:1]))
         CC_O:    cond = flags_ff.of;
         CC_B:    cond = flags_ff.cf;
         CC_E:    cond = flags_ff.zf;
         CC_BE:   cond = flags_ff.cf | flags_ff.zf;
         CC_S:    cond = flags_ff.sf;
         CC_P:    cond = flags_ff.pf;
         CC_L:    cond = flags_ff.sf ^ flags_ff.of;
         default: cond = flags_ff.zf | (flags_ff.sf ^ flags_ff.of);
      endcase
   end

   always_comb begin
      res        = '0;
      wb         = 1'b1;
      szp_update = 1'b0;
      co_clear   = 1'b0;
      unique case (work_item.kind)
         K_TEST: begin
            res        = dest & work_item.src;
            wb         = 1'b0;
            szp_update = 1'b1;
            co_clear   = 1'b1;
         end
         K_AND: begin
            res        = dest & work_item.src;
            szp_update = 1'b1;
            co_clear   = 1'b1;
         end
         K_XOR: begin
            res        = dest ^ work_item.src;
            szp_update = 1'b1;
            co_clear   = 1'b1;
         end
         K_OR: begin
            res        = dest | work_item.src;
            szp_update = 1'b1;
            co_clear   = 1'b1;
         end
         K_SAR: begin
            res        = ((dest >> work_item.count) | sar_fill) & mask;
            szp_update = 1'b1;
         end
         K_SHL: begin
            res        = (dest << work_item.count) & mask;
            szp_update = 1'b1;
         end
         K_SHR: begin
            res        = dest >> work_item.count;
            szp_update = 1'b1;
         end
         K_SETCC: begin
            res = {{(DataWidth-1){1'b0}}, cond ^ work_item.condition[0]};
         end
         K_NOT: begin
            res = ~dest & mask;
         end
         K_SHRD: begin
            if (work_item.count == '0) begin
               res = work_item.dest;
            end else begin
               res = (work_item.dest >> work_item.count)
                   | (work_item.src2 << back_count);
            end
         end
         default: begin
            res = '0;
            wb  = 1'b0;
         end
      endcase
   end

   always_comb begin
      flags_in = flags_ff;
      if (pop && szp_update) begin
         flags_in.pf = ~^res[7:0];
         flags_in.zf = res == '0;
         flags_in.sf = top_bit(res, work_item.width);
         if (co_clear) begin
            flags_in.cf = 1'b0;
            flags_in.of = 1'b0;
         end
      end
   end

   assign pop = work_valid & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      rsp_in               = rsp_ff;
      if (pop) begin
         rsp_in.result        = res;
         rsp_in.write_back    = wb;
         rsp_in.carry_flag    = flags_in.cf;
         rsp_in.overflow_flag = flags_in.of;
         rsp_in.sign_flag     = flags_in.sf;
         rsp_in.zero_flag     = flags_in.zf;
         rsp_in.parity_flag   = flags_in.pf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== sv/x86_logic_shift_unit_top.sv =====
// An accepted item is written into the queue, then executed and registered in rsp_ff.
// Throughput: one item per cycle unless rsp stalls; the execute-stage flag register is
// read or written by an item as it executes, so items never wait on each other.
// A two-entry queue parts intake from execution, so each side stalls on its own.
// Reset clears the flags to zero, empties the queue and drops any pending result.
module x86_logic_shift_unit_top
   import xlsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic     queue_full;
   logic     push;
   work_type push_item;
   logic     pop_valid;
   logic     pop;
   work_type pop_item;

   xlsu_front u_front (
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   xlsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_item  (pop_item)
   );

   xlsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_valid (pop_valid),
      .work_item  (pop_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule
